// File: hw/rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and codes for the cursor list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [3:0] {
        OP_APPEND      = 4'd0,
        OP_PREPEND     = 4'd1,
        OP_INS_BEFORE  = 4'd2,
        OP_INS_AFTER   = 4'd3,
        OP_DEL_FRONT   = 4'd4,
        OP_DEL_BACK    = 4'd5,
        OP_DEL_CURSOR  = 4'd6,
        OP_SET         = 4'd7,
        OP_MOVE_FRONT  = 4'd8,
        OP_MOVE_BACK   = 4'd9,
        OP_PREV        = 4'd10,
        OP_NEXT        = 4'd11,
        OP_CLEAR       = 4'd12,
        OP_READ        = 4'd13
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOCURSOR = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_RDA,
        BS_RDB,
        BS_WR1,
        BS_WR2,
        BS_REF0,
        BS_REF1,
        BS_REF2,
        BS_REF3
    } t_bstate;

    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] value;
    } t_cmd;

endpackage

// File: hw/rtl/cle_front.sv
// ----------------------------------------------------------------------------
// cle_front
// Accepts command words, decodes the operation and queues them for the back.
// ----------------------------------------------------------------------------
module cle_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [3:0]           i_operation,
    input  logic [31:0]          i_value,
    output logic                 o_cmd_valid,
    output cle_pkg::t_cmd        o_cmd,
    input  logic                 i_cmd_pop
);
    import cle_pkg::*;

    t_cmd        r_queue [2];
    logic        r_wptr;
    logic        n_wptr;
    logic        r_rptr;
    logic        n_rptr;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        push;
    logic        pop;
    t_cmd        dec;

    always_comb begin
        dec.value = i_value;
        if (i_operation > 4'(OP_READ)) begin
            dec.op = OP_READ;
        end else begin
            dec.op = t_op'(i_operation);
        end
    end

    assign busy        = (r_cnt == 2'd2);
    assign push        = start && !busy;
    assign pop         = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_queue[r_rptr];

    always_comb begin
        n_wptr = push ? ~r_wptr : r_wptr;
        n_rptr = pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wptr] <= dec;
        end
    end

endmodule

// File: hw/rtl/cle_back.sv
// ----------------------------------------------------------------------------
// cle_back
// Runs list operations on the node memories and builds the result word.
// ----------------------------------------------------------------------------
module cle_back #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  cle_pkg::t_cmd        i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [8:0]           o_list_length,
    output logic                 o_cursor_defined,
    output logic [7:0]           o_cursor_position,
    output logic [31:0]          o_cursor_value,
    output logic [31:0]          o_front_value,
    output logic [31:0]          o_back_value
);
    import cle_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [DATA_WIDTH-1:0] r_data_mem [CAPACITY];
    logic [AW-1:0]         r_next_mem [CAPACITY];
    logic [AW-1:0]         r_prev_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rd_d;
    logic [AW-1:0]         r_rd_n;
    logic [AW-1:0]         r_rd_p;

    logic                  we_d;
    logic [AW-1:0]         wa_d;
    logic [DATA_WIDTH-1:0] wd_d;
    logic [AW-1:0]         ra_d;
    logic                  we_n;
    logic [AW-1:0]         wa_n;
    logic [AW-1:0]         wd_n;
    logic [AW-1:0]         ra_n;
    logic                  we_p;
    logic [AW-1:0]         wa_p;
    logic [AW-1:0]         wd_p;
    logic [AW-1:0]         ra_p;

    t_bstate               r_state, n_state;
    t_op                   r_op, n_op;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_tail, n_tail;
    logic [AW-1:0]         r_cur, n_cur;
    logic [AW-1:0]         r_ccnt, n_ccnt;
    logic                  r_cvalid, n_cvalid;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_fhead, n_fhead;
    logic [CW-1:0]         r_fcount, n_fcount;
    logic [CW-1:0]         r_fresh, n_fresh;
    logic [AW-1:0]         r_an, n_an;
    logic [AW-1:0]         r_ap, n_ap;
    t_status               r_status, n_status;
    logic                  r_w2n_en, n_w2n_en;
    logic [AW-1:0]         r_w2n_addr, n_w2n_addr;
    logic [AW-1:0]         r_w2n_data, n_w2n_data;
    logic                  r_w2p_en, n_w2p_en;
    logic [AW-1:0]         r_w2p_addr, n_w2p_addr;
    logic [AW-1:0]         r_w2p_data, n_w2p_data;
    logic [DATA_WIDTH-1:0] r_front, n_front;
    logic [DATA_WIDTH-1:0] r_back, n_back;

    logic                  r_o_valid, n_o_valid;
    logic [1:0]            r_o_status, n_o_status;
    logic [8:0]            r_o_len, n_o_len;
    logic                  r_o_cdef, n_o_cdef;
    logic [7:0]            r_o_cpos, n_o_cpos;
    logic [31:0]           r_o_cval, n_o_cval;
    logic [31:0]           r_o_fval, n_o_fval;
    logic [31:0]           r_o_bval, n_o_bval;

    logic                  empty;
    logic                  full;
    logic [AW-1:0]         alloc_n;
    logic                  alloc_go;
    logic                  free_go;
    logic [AW-1:0]         free_n;
    logic                  drop;

    always_ff @(posedge i_clk) begin
        if (we_d) begin
            r_data_mem[wa_d] <= wd_d;
        end
        if (we_n) begin
            r_next_mem[wa_n] <= wd_n;
        end
        if (we_p) begin
            r_prev_mem[wa_p] <= wd_p;
        end
        r_rd_d <= r_data_mem[ra_d];
        r_rd_n <= r_next_mem[ra_n];
        r_rd_p <= r_prev_mem[ra_p];
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_val      = r_val;
        n_head     = r_head;
        n_tail     = r_tail;
        n_cur      = r_cur;
        n_ccnt     = r_ccnt;
        n_cvalid   = r_cvalid;
        n_count    = r_count;
        n_fhead    = r_fhead;
        n_fcount   = r_fcount;
        n_fresh    = r_fresh;
        n_an       = r_an;
        n_ap       = r_ap;
        n_status   = r_status;
        n_w2n_en   = r_w2n_en;
        n_w2n_addr = r_w2n_addr;
        n_w2n_data = r_w2n_data;
        n_w2p_en   = r_w2p_en;
        n_w2p_addr = r_w2p_addr;
        n_w2p_data = r_w2p_data;
        n_front    = r_front;
        n_back     = r_back;
        n_o_valid  = 1'b0;
        n_o_status = r_o_status;
        n_o_len    = r_o_len;
        n_o_cdef   = r_o_cdef;
        n_o_cpos   = r_o_cpos;
        n_o_cval   = r_o_cval;
        n_o_fval   = r_o_fval;
        n_o_bval   = r_o_bval;
        o_cmd_pop  = 1'b0;
        we_d       = 1'b0;
        wa_d       = r_cur;
        wd_d       = r_val;
        ra_d       = r_head;
        we_n       = 1'b0;
        wa_n       = r_cur;
        wd_n       = '0;
        ra_n       = r_cur;
        we_p       = 1'b0;
        wa_p       = r_cur;
        wd_p       = '0;
        ra_p       = r_cur;
        alloc_go   = 1'b0;
        free_go    = 1'b0;
        free_n     = r_cur;
        drop       = 1'b0;

        empty   = (r_count == '0);
        full    = !((r_count < CAP_C) && ((r_fcount != '0) || (r_fresh < CAP_C)));
        alloc_n = (r_fcount != '0) ? r_fhead : r_fresh[AW-1:0];

        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_op      = i_cmd.op;
                    n_val     = DATA_WIDTH'(i_cmd.value);
                    n_state   = BS_RDA;
                end
            end
            BS_RDA: begin
                unique case (r_op) inside
                    OP_APPEND, OP_PREPEND, OP_INS_BEFORE, OP_INS_AFTER: ra_n = r_fhead;
                    OP_DEL_FRONT: ra_n = r_head;
                    OP_DEL_BACK:  ra_p = r_tail;
                    default: ;
                endcase
                n_state = BS_RDB;
            end
            BS_RDB: begin
                n_an    = r_rd_n;
                n_ap    = r_rd_p;
                n_state = BS_WR1;
            end
            BS_WR1: begin
                n_status = ST_OK;
                n_w2n_en = 1'b0;
                n_w2p_en = 1'b0;
                unique case (r_op) inside
                    OP_APPEND, OP_PREPEND: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            alloc_go = 1'b1;
                            we_d = 1'b1;
                            wa_d = alloc_n;
                            we_n = 1'b1;
                            wa_n = alloc_n;
                            we_p = 1'b1;
                            wa_p = alloc_n;
                            if (empty) begin
                                n_head = alloc_n;
                                n_tail = alloc_n;
                            end else if (r_op == OP_APPEND) begin
                                wd_p       = r_tail;
                                n_tail     = alloc_n;
                                n_w2n_en   = 1'b1;
                                n_w2n_addr = r_tail;
                                n_w2n_data = alloc_n;
                            end else begin
                                wd_n       = r_head;
                                n_head     = alloc_n;
                                n_w2p_en   = 1'b1;
                                n_w2p_addr = r_head;
                                n_w2p_data = alloc_n;
                                if (r_cvalid) begin
                                    n_ccnt = r_ccnt + AW'(1);
                                end
                            end
                        end
                    end
                    OP_INS_BEFORE, OP_INS_AFTER: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else if (!r_cvalid) begin
                            n_status = ST_NOCURSOR;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            alloc_go = 1'b1;
                            we_d = 1'b1;
                            wa_d = alloc_n;
                            we_n = 1'b1;
                            wa_n = alloc_n;
                            we_p = 1'b1;
                            wa_p = alloc_n;
                            if (r_op == OP_INS_BEFORE) begin
                                wd_n = r_cur;
                                wd_p = r_rd_p;
                                if (r_cur == r_head) begin
                                    n_head = alloc_n;
                                end else begin
                                    n_w2n_en   = 1'b1;
                                    n_w2n_addr = r_rd_p;
                                    n_w2n_data = alloc_n;
                                end
                                n_w2p_en   = 1'b1;
                                n_w2p_addr = r_cur;
                                n_w2p_data = alloc_n;
                                n_ccnt     = r_ccnt + AW'(1);
                            end else begin
                                wd_p = r_cur;
                                wd_n = r_rd_n;
                                if (r_cur == r_tail) begin
                                    n_tail = alloc_n;
                                end else begin
                                    n_w2p_en   = 1'b1;
                                    n_w2p_addr = r_rd_n;
                                    n_w2p_data = alloc_n;
                                end
                                n_w2n_en   = 1'b1;
                                n_w2n_addr = r_cur;
                                n_w2n_data = alloc_n;
                            end
                        end
                    end
                    OP_DEL_FRONT: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            free_go = 1'b1;
                            free_n  = r_head;
                            if (r_cvalid && (r_cur == r_head)) begin
                                drop = 1'b1;
                            end else if (r_cvalid) begin
                                n_ccnt = r_ccnt - AW'(1);
                            end
                            n_head = r_an;
                        end
                    end
                    OP_DEL_BACK: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            free_go = 1'b1;
                            free_n  = r_tail;
                            if (r_cvalid && (r_cur == r_tail)) begin
                                drop = 1'b1;
                            end
                            n_tail = r_ap;
                        end
                    end
                    OP_DEL_CURSOR: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else if (!r_cvalid) begin
                            n_status = ST_NOCURSOR;
                        end else begin
                            free_go = 1'b1;
                            free_n  = r_cur;
                            drop    = 1'b1;
                            if (r_cur == r_head) begin
                                n_head = r_an;
                            end else begin
                                n_w2n_en   = 1'b1;
                                n_w2n_addr = r_ap;
                                n_w2n_data = r_an;
                            end
                            if (r_cur == r_tail) begin
                                n_tail = r_ap;
                            end else begin
                                n_w2p_en   = 1'b1;
                                n_w2p_addr = r_an;
                                n_w2p_data = r_ap;
                            end
                        end
                    end
                    OP_SET: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else if (!r_cvalid) begin
                            n_status = ST_NOCURSOR;
                        end else begin
                            we_d = 1'b1;
                            wa_d = r_cur;
                        end
                    end
                    OP_MOVE_FRONT: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_cvalid = 1'b1;
                            n_cur    = r_head;
                            n_ccnt   = '0;
                        end
                    end
                    OP_MOVE_BACK: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_cvalid = 1'b1;
                            n_cur    = r_tail;
                            n_ccnt   = AW'(r_count - CW'(1));
                        end
                    end
                    OP_PREV: begin
                        if (r_cvalid) begin
                            if (r_cur == r_head) begin
                                drop = 1'b1;
                            end else begin
                                n_cur  = r_ap;
                                n_ccnt = r_ccnt - AW'(1);
                            end
                        end
                    end
                    OP_NEXT: begin
                        if (r_cvalid) begin
                            if (r_cur == r_tail) begin
                                drop = 1'b1;
                            end else begin
                                n_cur  = r_an;
                                n_ccnt = r_ccnt + AW'(1);
                            end
                        end
                    end
                    OP_CLEAR: begin
                        drop     = 1'b1;
                        n_head   = '0;
                        n_tail   = '0;
                        n_count  = '0;
                        n_fhead  = '0;
                        n_fcount = '0;
                        n_fresh  = '0;
                    end
                    default: ;
                endcase

                if (alloc_go) begin
                    if (r_fcount != '0) begin
                        n_fhead  = r_an;
                        n_fcount = r_fcount - CW'(1);
                    end else begin
                        n_fresh = r_fresh + CW'(1);
                    end
                    n_count = r_count + CW'(1);
                end
                if (free_go) begin
                    we_n     = 1'b1;
                    wa_n     = free_n;
                    wd_n     = r_fhead;
                    n_fhead  = free_n;
                    n_fcount = r_fcount + CW'(1);
                    n_count  = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                end
                if (drop) begin
                    n_cvalid = 1'b0;
                    n_cur    = '0;
                    n_ccnt   = '0;
                end
                n_state = BS_WR2;
            end
            BS_WR2: begin
                we_n    = r_w2n_en;
                wa_n    = r_w2n_addr;
                wd_n    = r_w2n_data;
                we_p    = r_w2p_en;
                wa_p    = r_w2p_addr;
                wd_p    = r_w2p_data;
                n_state = BS_REF0;
            end
            BS_REF0: begin
                ra_d    = r_head;
                n_state = BS_REF1;
            end
            BS_REF1: begin
                n_front = r_rd_d;
                ra_d    = r_tail;
                n_state = BS_REF2;
            end
            BS_REF2: begin
                n_back  = r_rd_d;
                ra_d    = r_cur;
                n_state = BS_REF3;
            end
            BS_REF3: begin
                n_o_valid  = 1'b1;
                n_o_status = r_status;
                n_o_len    = 9'(r_count);
                n_o_cdef   = r_cvalid;
                n_o_cpos   = r_cvalid ? 8'(r_ccnt) : 8'd0;
                n_o_cval   = r_cvalid ? 32'(r_rd_d) : 32'd0;
                n_o_fval   = empty ? 32'd0 : 32'(r_front);
                n_o_bval   = empty ? 32'd0 : 32'(r_back);
                n_state    = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_cur     <= '0;
            r_ccnt    <= '0;
            r_cvalid  <= 1'b0;
            r_count   <= '0;
            r_fhead   <= '0;
            r_fcount  <= '0;
            r_fresh   <= '0;
            r_w2n_en  <= 1'b0;
            r_w2p_en  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_cur     <= n_cur;
            r_ccnt    <= n_ccnt;
            r_cvalid  <= n_cvalid;
            r_count   <= n_count;
            r_fhead   <= n_fhead;
            r_fcount  <= n_fcount;
            r_fresh   <= n_fresh;
            r_w2n_en  <= n_w2n_en;
            r_w2p_en  <= n_w2p_en;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_an       <= n_an;
        r_ap       <= n_ap;
        r_status   <= n_status;
        r_w2n_addr <= n_w2n_addr;
        r_w2n_data <= n_w2n_data;
        r_w2p_addr <= n_w2p_addr;
        r_w2p_data <= n_w2p_data;
        r_front    <= n_front;
        r_back     <= n_back;
        r_o_status <= n_o_status;
        r_o_len    <= n_o_len;
        r_o_cdef   <= n_o_cdef;
        r_o_cpos   <= n_o_cpos;
        r_o_cval   <= n_o_cval;
        r_o_fval   <= n_o_fval;
        r_o_bval   <= n_o_bval;
    end

    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_list_length     = r_o_len;
    assign o_cursor_defined  = r_o_cdef;
    assign o_cursor_position = r_o_cpos;
    assign o_cursor_value    = r_o_cval;
    assign o_front_value     = r_o_fval;
    assign o_back_value      = r_o_bval;

endmodule

// File: hw/rtl/cursor_list_engine.sv
// ----------------------------------------------------------------------------
// cursor_list_engine
// Bounded doubly linked list with one cursor, free list and status report.
//
//   Channel   Handshake          Ports
//   command   start and !busy    i_operation, i_value
//   result    o_valid strobe     o_status, o_list_length, o_cursor_*, o_front_value,
//                                o_back_value
//
// Each word runs through the back end in turn: taking it from the queue,
// two link reads, two link writes, three data reads for the front, back and
// cursor words, and the result step; the registered strobe follows in the next cycle.
// Up to two words wait in the queue while the back end works; busy rises when
// it is full. The result strobe lasts one cycle and cannot be held off.
// Synchronous reset empties the list and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cursor_list_engine #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_operation,
    input  logic [31:0] i_value,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [8:0]  o_list_length,
    output logic        o_cursor_defined,
    output logic [7:0]  o_cursor_position,
    output logic [31:0] o_cursor_value,
    output logic [31:0] o_front_value,
    output logic [31:0] o_back_value
);
    import cle_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    cle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    cle_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (cmd),
        .o_cmd_pop         (cmd_pop),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_list_length     (o_list_length),
        .o_cursor_defined  (o_cursor_defined),
        .o_cursor_position (o_cursor_position),
        .o_cursor_value    (o_cursor_value),
        .o_front_value     (o_front_value),
        .o_back_value      (o_back_value)
    );

endmodule
